/* rtl/core/tsp_pkg.sv */
// tsp_pkg: shared widths, register indexes, sideband types and the step
// functions of the torus support point datapath. No dependencies.
package tsp_pkg;

   localparam int DirW          = 16;
   localparam int RadW          = 31;
   localparam int PointW        = 34;
   localparam int TubeW         = 32;
   localparam int SumW          = 32;
   localparam int RootW         = 16;
   localparam int RemW          = 18;
   localparam int RadialW       = 50;
   localparam int RadialMagW    = 48;
   localparam int HalfMagW      = 24;
   localparam int NumW          = 50;
   localparam int QuoW          = 36;
   localparam int StepsPerStage = 4;
   localparam int CsrIdxW       = 2;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MAJOR  = 2'd0,
      CSR_MINOR  = 2'd1,
      CSR_MARGIN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
      logic [SumW-1:0]  rad;
   } sqrt_state_type;

   typedef struct packed {
      logic [RootW-1:0] rem;
      logic [QuoW-1:0]  low;
      logic [QuoW-1:0]  quo;
   } div_state_type;

   typedef struct packed {
      logic                    zero;
      logic                    xneg;
      logic                    zneg;
      logic [DirW-1:0]         ax;
      logic [DirW-1:0]         az;
      logic signed [DirW-1:0]  y;
      logic signed [TubeW-1:0] t;
   } sq_side_type;

   typedef struct packed {
      logic                     zero;
      logic                     xneg;
      logic                     zneg;
      logic                     rneg;
      logic signed [PointW-1:0] point_y;
   } div_side_type;

   // four digit-by-digit square root steps, two radicand bits each
   function automatic sqrt_state_type sqrt_step4(sqrt_state_type s_in);
      sqrt_state_type  s;
      logic [RemW-1:0] r;
      logic [RemW-1:0] trial;
      s = s_in;
      for (int i = 0; i < StepsPerStage; i++) begin
         r     = {s.rem[RemW-3:0], s.rad[SumW-1:SumW-2]};
         s.rad = {s.rad[SumW-3:0], 2'b00};
         trial = {s.root, 2'b01};
         if (r >= trial) begin
            r      = r - trial;
            s.root = {s.root[RootW-2:0], 1'b1};
         end else begin
            s.root = {s.root[RootW-2:0], 1'b0};
         end
         s.rem = r;
      end
      return s;
   endfunction

   // four restoring division steps, one quotient bit each
   function automatic div_state_type div_step4(div_state_type s_in,
                                               logic [RootW-1:0] den);
      div_state_type  s;
      logic [RootW:0] r;
      s = s_in;
      for (int i = 0; i < StepsPerStage; i++) begin
         r     = {s.rem, s.low[QuoW-1]};
         s.low = {s.low[QuoW-2:0], 1'b0};
         if (r >= {1'b0, den}) begin
            r     = r - {1'b0, den};
            s.quo = {s.quo[QuoW-2:0], 1'b1};
         end else begin
            s.quo = {s.quo[QuoW-2:0], 1'b0};
         end
         s.rem = r[RootW-1:0];
      end
      return s;
   endfunction

   // sign and magnitude to saturated two's complement
   function automatic logic signed [PointW-1:0] pack34(logic neg,
                                                       logic [RadialMagW-1:0] mag);
      logic [RadialMagW-1:0] lim;
      logic [RadialMagW-1:0] m;
      lim = neg ? (RadialMagW'(1) << (PointW-1)) : ((RadialMagW'(1) << (PointW-1)) - 1'b1);
      m   = (mag > lim) ? lim : mag;
      return neg ? $signed(-m[PointW-1:0]) : $signed(m[PointW-1:0]);
   endfunction

endpackage

/* rtl/core/tsp_delay.sv */
// tsp_delay: enabled register line that keeps sideband aligned with a
// pipelined unit. No package dependency.
module tsp_delay #(
   parameter int Width = 1,
   parameter int Depth = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [Width-1:0] din,
   output logic [Width-1:0] dout
);

   logic [Width-1:0] data_ff [Depth];

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= din;
      end
   end

   for (genvar g = 1; g < Depth; g++) begin : g_tap
      always_ff @(posedge clock) begin
         if (en) begin
            data_ff[g] <= data_ff[g-1];
         end
      end
   end

   assign dout = data_ff[Depth-1];

endmodule

/* rtl/core/tsp_isqrt.sv */
// tsp_isqrt: pipelined integer square root, four root bits per stage.
// Depends on tsp_pkg.
module tsp_isqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [tsp_pkg::SumW-1:0]    rad,
   output logic [tsp_pkg::RootW-1:0]   root
);
   import tsp_pkg::*;

   localparam int Stages = RootW / StepsPerStage;

   sqrt_state_type st_ff [Stages];
   sqrt_state_type st_in [Stages];
   sqrt_state_type seed;

   always_comb begin
      seed.rem  = '0;
      seed.root = '0;
      seed.rad  = rad;
   end

   for (genvar g = 0; g < Stages; g++) begin : g_stage
      if (g == 0) begin : g_first
         always_comb st_in[g] = sqrt_step4(seed);
      end else begin : g_next
         always_comb st_in[g] = sqrt_step4(st_ff[g-1]);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   assign root = st_ff[Stages-1].root;

endmodule

/* rtl/core/tsp_div.sv */
// tsp_div: pipelined restoring divider, four quotient bits per stage, with
// an overflow flag for quotients beyond the quotient width. Depends on tsp_pkg.
module tsp_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [tsp_pkg::NumW-1:0]    num,
   input  logic [tsp_pkg::RootW-1:0]   den,
   output logic [tsp_pkg::QuoW-1:0]    quo,
   output logic                        ovf
);
   import tsp_pkg::*;

   localparam int Stages = QuoW / StepsPerStage;

   div_state_type    st_ff  [Stages];
   div_state_type    st_in  [Stages];
   logic [RootW-1:0] den_ff [Stages];
   logic             ovf_ff [Stages];
   div_state_type    seed;
   logic             ovf_in;

   always_comb begin
      seed.rem = RootW'(num[NumW-1:QuoW]);
      seed.low = num[QuoW-1:0];
      seed.quo = '0;
      ovf_in   = RootW'(num[NumW-1:QuoW]) >= den;
   end

   for (genvar g = 0; g < Stages; g++) begin : g_stage
      if (g == 0) begin : g_first
         always_comb st_in[g] = div_step4(seed, den);
         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[g] <= den;
               ovf_ff[g] <= ovf_in;
            end
         end
      end else begin : g_next
         always_comb st_in[g] = div_step4(st_ff[g-1], den_ff[g-1]);
         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[g] <= den_ff[g-1];
               ovf_ff[g] <= ovf_ff[g-1];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   assign quo = st_ff[Stages-1].quo;
   assign ovf = ovf_ff[Stages-1];

endmodule

/* rtl/core/torus_support_point.sv */
// torus_support_point: top level of the torus support point pipeline.
// Depends on tsp_pkg, tsp_delay, tsp_isqrt and tsp_div.
//
// Maps a Q1.14 direction to the farthest point of a Y-axis torus, in Q17.16,
// saturated to 34 bits. One transaction is accepted per cycle while the
// pipeline is not held; results pass through the 16-bit square root (four
// bits per stage) and the 36-bit quotient (four bits per stage). The whole
// pipeline holds while a response waits on rsp_ready.
// Radius registers must be written while no transaction is in flight.
module torus_support_point (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [tsp_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [tsp_pkg::RadW-1:0]           csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_type,
   input  logic signed [tsp_pkg::DirW-1:0]    req_dir_x,
   input  logic signed [tsp_pkg::DirW-1:0]    req_dir_y,
   input  logic signed [tsp_pkg::DirW-1:0]    req_dir_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tsp_pkg::PointW-1:0]  rsp_point_x,
   output logic signed [tsp_pkg::PointW-1:0]  rsp_point_y,
   output logic signed [tsp_pkg::PointW-1:0]  rsp_point_z
);
   import tsp_pkg::*;

   localparam int SqrtStages = RootW / StepsPerStage;
   localparam int DivStages  = QuoW / StepsPerStage;
   localparam int Lat        = 1 + SqrtStages + 4 + DivStages + 1;

   logic [RadW-1:0] major_ff, minor_ff, margin_ff;
   logic [Lat-1:0]  v_ff, v_in;
   logic            en;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff  <= RadW'(65536);
         minor_ff  <= RadW'(16384);
         margin_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MAJOR:  major_ff  <= csr_wdata;
            CSR_MINOR:  minor_ff  <= csr_wdata;
            CSR_MARGIN: margin_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid line
   assign en        = !v_ff[Lat-1] || rsp_ready;
   assign req_ready = en && !reset;
   assign rsp_valid = v_ff[Lat-1];
   assign v_in      = {v_ff[Lat-2:0], req_valid && req_ready};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // stage 1: magnitudes, tube radius, x^2 + z^2
   sq_side_type     p1_side_ff, p1_side_in;
   logic [SumW-1:0] p1_sum_ff, p1_sum_in;

   always_comb begin
      p1_side_in.zero = (req_dir_x == '0) && (req_dir_z == '0);
      p1_side_in.xneg = req_dir_x[DirW-1];
      p1_side_in.zneg = req_dir_z[DirW-1];
      p1_side_in.ax   = req_dir_x[DirW-1] ? DirW'(-req_dir_x) : DirW'(req_dir_x);
      p1_side_in.az   = req_dir_z[DirW-1] ? DirW'(-req_dir_z) : DirW'(req_dir_z);
      p1_side_in.y    = req_dir_y;
      p1_side_in.t    = $signed({1'b0, minor_ff})
                      - (req_type ? $signed({1'b0, margin_ff}) : TubeW'(0));
      p1_sum_in       = SumW'(p1_side_in.ax) * SumW'(p1_side_in.ax)
                      + SumW'(p1_side_in.az) * SumW'(p1_side_in.az);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_side_ff <= p1_side_in;
         p1_sum_ff  <= p1_sum_in;
      end
   end

   // stages 2-5: square root
   logic [RootW-1:0] p5_s14;
   sq_side_type      p5_side;

   tsp_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .rad   (p1_sum_ff),
      .root  (p5_s14)
   );

   tsp_delay #(.Width($bits(sq_side_type)), .Depth(SqrtStages)) u_sq_side (
      .clock (clock),
      .en    (en),
      .din   (p1_side_ff),
      .dout  (p5_side)
   );

   // stage 6: t*s, |t|*|y|
   logic signed [RadialW-2:0] p6_prod_ff, p6_prod_in;
   logic [RadialMagW-1:0]     p6_ymul_ff, p6_ymul_in;
   logic [RootW-1:0]          p6_s14_ff;
   sq_side_type               p6_side_ff;
   logic [TubeW-1:0]          abs_t;
   logic [DirW-1:0]           abs_y;

   always_comb begin
      abs_t      = p5_side.t[TubeW-1] ? TubeW'(-p5_side.t) : TubeW'(p5_side.t);
      abs_y      = p5_side.y[DirW-1] ? DirW'(-p5_side.y) : DirW'(p5_side.y);
      p6_prod_in = p5_side.t * $signed({1'b0, p5_s14});
      p6_ymul_in = RadialMagW'(abs_t) * RadialMagW'(abs_y);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p6_prod_ff <= p6_prod_in;
         p6_ymul_ff <= p6_ymul_in;
         p6_s14_ff  <= p5_s14;
         p6_side_ff <= p5_side;
      end
   end

   // stage 7: radial term, point_y
   logic signed [RadialW-1:0] radial;
   logic [RadialMagW-1:0]     p7_rmag_ff, p7_rmag_in;
   logic [RootW-1:0]          p7_s14_ff;
   logic [DirW-1:0]           p7_ax_ff, p7_az_ff;
   div_side_type              p7_side_ff, p7_side_in;
   logic signed [PointW-1:0]  t34;
   logic                      yneg;

   always_comb begin
      radial = $signed({5'b0, major_ff, 14'b0}) + RadialW'(p6_prod_ff);
      p7_rmag_in = radial[RadialW-1] ? RadialMagW'(-radial) : radial[RadialMagW-1:0];
      t34  = PointW'(p6_side_ff.t);
      yneg = p6_side_ff.y[DirW-1];
      p7_side_in.zero = p6_side_ff.zero;
      p7_side_in.xneg = p6_side_ff.xneg;
      p7_side_in.zneg = p6_side_ff.zneg;
      p7_side_in.rneg = radial[RadialW-1];
      if (p6_side_ff.zero) begin
         p7_side_in.point_y = yneg ? -t34 : t34;
      end else begin
         p7_side_in.point_y = pack34(p6_side_ff.t[TubeW-1] != yneg,
                                     (p6_ymul_ff + RadialMagW'(8192)) >> 14);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p7_rmag_ff <= p7_rmag_in;
         p7_s14_ff  <= p6_s14_ff;
         p7_ax_ff   <= p6_side_ff.ax;
         p7_az_ff   <= p6_side_ff.az;
         p7_side_ff <= p7_side_in;
      end
   end

   // stage 8: partial products of |x|*rmag, |z|*rmag
   localparam int PartW = DirW + HalfMagW;
   logic [PartW-1:0] p8_xlo_ff, p8_xhi_ff, p8_zlo_ff, p8_zhi_ff;
   logic [RootW-1:0] p8_s14_ff;
   div_side_type     p8_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p8_xlo_ff  <= PartW'(p7_ax_ff) * PartW'(p7_rmag_ff[HalfMagW-1:0]);
         p8_xhi_ff  <= PartW'(p7_ax_ff) * PartW'(p7_rmag_ff[RadialMagW-1:HalfMagW]);
         p8_zlo_ff  <= PartW'(p7_az_ff) * PartW'(p7_rmag_ff[HalfMagW-1:0]);
         p8_zhi_ff  <= PartW'(p7_az_ff) * PartW'(p7_rmag_ff[RadialMagW-1:HalfMagW]);
         p8_s14_ff  <= p7_s14_ff;
         p8_side_ff <= p7_side_ff;
      end
   end

   // stage 9: dividend with rounding half, scaled by 2^-14
   localparam int WideW = 64;
   logic [WideW-1:0] nx, nz, half;
   logic [NumW-1:0]  p9_numx_ff, p9_numz_ff;
   logic [RootW-1:0] p9_s14_ff;
   div_side_type     p9_side_ff;

   always_comb begin
      half = WideW'(p8_s14_ff) << 13;
      nx   = (WideW'(p8_xhi_ff) << HalfMagW) + WideW'(p8_xlo_ff) + half;
      nz   = (WideW'(p8_zhi_ff) << HalfMagW) + WideW'(p8_zlo_ff) + half;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p9_numx_ff <= nx[WideW-1:14];
         p9_numz_ff <= nz[WideW-1:14];
         p9_s14_ff  <= p8_s14_ff;
         p9_side_ff <= p8_side_ff;
      end
   end

   // stages 10-18: division by s
   logic [QuoW-1:0] quox, quoz;
   logic            ovfx, ovfz;
   div_side_type    div_side_out;

   tsp_div u_div_x (
      .clock (clock),
      .en    (en),
      .num   (p9_numx_ff),
      .den   (p9_s14_ff),
      .quo   (quox),
      .ovf   (ovfx)
   );

   tsp_div u_div_z (
      .clock (clock),
      .en    (en),
      .num   (p9_numz_ff),
      .den   (p9_s14_ff),
      .quo   (quoz),
      .ovf   (ovfz)
   );

   tsp_delay #(.Width($bits(div_side_type)), .Depth(DivStages)) u_div_side (
      .clock (clock),
      .en    (en),
      .din   (p9_side_ff),
      .dout  (div_side_out)
   );

   // stage 19: saturate, zero-direction select, output register
   logic signed [PointW-1:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic [RadialMagW-1:0]    magx, magz;

   always_comb begin
      magx  = ovfx ? '1 : RadialMagW'(quox);
      magz  = ovfz ? '1 : RadialMagW'(quoz);
      py_in = div_side_out.point_y;
      if (div_side_out.zero) begin
         px_in = $signed(PointW'(major_ff));
         pz_in = '0;
      end else begin
         px_in = pack34(div_side_out.rneg ^ div_side_out.xneg, magx);
         pz_in = pack34(div_side_out.rneg ^ div_side_out.zneg, magz);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
      end
   end

   assign rsp_point_x = px_ff;
   assign rsp_point_y = py_ff;
   assign rsp_point_z = pz_ff;

`ifndef NO_ASSERTIONS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> v_ff == $past(v_ff))
      else $error("pipeline valids moved during stall");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v_ff[0])
      else $error("accepted transaction missing from first stage");

   a_zero_dir: assert property (@(posedge clock) disable iff (reset)
      (en && v_ff[Lat-2] && div_side_out.zero) |=> (rsp_point_z == '0))
      else $error("zero horizontal direction gave nonzero z");
`endif

endmodule

/* tb/sv/tb_top.sv */
// tb_top: self-checking testbench for torus_support_point.
// Depends on tsp_pkg and the torus_support_point RTL; checks every response
// against a built-in predictor or table values under several radius settings.
`timescale 1ns / 100ps

module tb_top;
   import tsp_pkg::*;

   typedef struct {
      logic signed [PointW-1:0] px;
      logic signed [PointW-1:0] py;
      logic signed [PointW-1:0] pz;
   } point_type;

   typedef struct {
      bit                     typ;
      logic signed [DirW-1:0] dx;
      logic signed [DirW-1:0] dy;
      logic signed [DirW-1:0] dz;
      bit                     known;
      point_type              pt;
   } dir_row_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CsrIdxW-1:0]        csr_index;
   logic [RadW-1:0]           csr_wdata;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_type;
   logic signed [DirW-1:0]    req_dir_x;
   logic signed [DirW-1:0]    req_dir_y;
   logic signed [DirW-1:0]    req_dir_z;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [PointW-1:0]  rsp_point_x;
   logic signed [PointW-1:0]  rsp_point_y;
   logic signed [PointW-1:0]  rsp_point_z;

   logic [RadW-1:0] major_r;
   logic [RadW-1:0] minor_r;
   logic [RadW-1:0] margin_r;

   point_type   pending_points[$];
   dir_row_type dir_table[$];
   int          errors;
   int          sent;
   int          checked;
   int          burst_left;
   int          stall_mode;
   int          stall_left;

   torus_support_point DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y), .rsp_point_z(rsp_point_z)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("Timeout at %0t", $time);
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [63:0] abs64(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic logic signed [PointW-1:0] clamp34(bit neg, logic [63:0] m);
      logic [63:0] lim;
      lim = neg ? (64'd1 << 33) : ((64'd1 << 33) - 1);
      if (m > lim) m = lim;
      return neg ? PointW'(-m) : PointW'(m);
   endfunction

   function automatic point_type torus_point(bit typ, logic signed [DirW-1:0] dx,
                                             logic signed [DirW-1:0] dy,
                                             logic signed [DirW-1:0] dz);
      point_type   p;
      longint      x, y, z, t, rr, radial;
      logic [63:0] sum, s14, den, rmag;
      bit          rneg;
      x = dx;
      y = dy;
      z = dz;
      t = longint'({33'd0, minor_r});
      if (typ) t = t - longint'({33'd0, margin_r});
      rr = longint'({33'd0, major_r});
      sum = 64'(x * x + z * z);
      if (sum == 0) begin
         p.px = clamp34(rr < 0, abs64(rr));
         p.py = (y < 0) ? clamp34(t > 0, abs64(t)) : clamp34(t < 0, abs64(t));
         p.pz = '0;
         return p;
      end
      s14 = floor_root(sum);
      radial = rr * 16384 + t * longint'(s14);
      rneg = radial < 0;
      rmag = abs64(radial);
      den = s14 << 14;
      p.px = clamp34(rneg != (x < 0), (abs64(x) * rmag + den / 2) / den);
      p.py = clamp34((t < 0) != (y < 0), (abs64(t) * abs64(y) + 8192) / 16384);
      p.pz = clamp34(rneg != (z < 0), (abs64(z) * rmag + den / 2) / den);
      return p;
   endfunction

   // response side: compare, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_points.size() == 0) begin
               $display("%0t: unexpected transaction x=%0d y=%0d z=%0d", $time,
                        rsp_point_x, rsp_point_y, rsp_point_z);
               errors++;
            end else begin
               point_type e;
               e = pending_points.pop_front();
               checked++;
               if (rsp_point_x !== e.px) begin
                  $display("%0t: point_x expected %0d actual %0d", $time, e.px, rsp_point_x);
                  errors++;
               end
               if (rsp_point_y !== e.py) begin
                  $display("%0t: point_y expected %0d actual %0d", $time, e.py, rsp_point_y);
                  errors++;
               end
               if (rsp_point_z !== e.pz) begin
                  $display("%0t: point_z expected %0d actual %0d", $time, e.pz, rsp_point_z);
                  errors++;
               end
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 80);
         end
         stall_left--;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic write_csr(csr_index_type idx, logic [RadW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MAJOR: major_r = val;
         CSR_MINOR: minor_r = val;
         default:   margin_r = val;
      endcase
   endtask

   task automatic set_radii(logic [RadW-1:0] r_major, logic [RadW-1:0] r_minor,
                            logic [RadW-1:0] r_margin);
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      write_csr(CSR_MAJOR, r_major);
      write_csr(CSR_MINOR, r_minor);
      write_csr(CSR_MARGIN, r_margin);
      csr_we <= 1'b0;
   endtask

   // holds valid across back-to-back transactions; drops it only for a gap
   task automatic send_dir(dir_row_type row);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= row.typ;
      req_dir_x <= row.dx;
      req_dir_y <= row.dy;
      req_dir_z <= row.dz;
      do @(posedge clock); while (!req_ready);
      pending_points.push_back(row.known ? row.pt
                               : torus_point(row.typ, row.dx, row.dy, row.dz));
      sent++;
   endtask

   function automatic dir_row_type mk(bit typ, int x, int y, int z, bit known = 0,
                                      longint ex = 0, longint ey = 0, longint ez = 0);
      dir_row_type r;
      r.typ = typ;
      r.dx = DirW'(x);
      r.dy = DirW'(y);
      r.dz = DirW'(z);
      r.known = known;
      r.pt.px = PointW'(ex);
      r.pt.py = PointW'(ey);
      r.pt.pz = PointW'(ez);
      return r;
   endfunction

   function automatic logic signed [DirW-1:0] rand_comp();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         3: return DirW'($urandom_range(0, 32) - 16);
         default: return DirW'($urandom);
      endcase
   endfunction

   task automatic random_dirs(int count);
      dir_row_type r;
      for (int i = 0; i < count; i++) begin
         r.typ = 1'($urandom_range(0, 1));
         r.dx = rand_comp();
         r.dy = rand_comp();
         r.dz = rand_comp();
         if ($urandom_range(0, 9) == 0) begin
            r.dx = '0;
            r.dz = '0;
         end
         r.known = 0;
         send_dir(r);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_MAJOR;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_type = 1'b0;
      req_dir_x = '0;
      req_dir_y = '0;
      req_dir_z = '0;
      errors = 0;
      sent = 0;
      checked = 0;
      burst_left = 0;
      major_r = 31'd65536;
      minor_r = 31'd16384;
      margin_r = 31'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset radii: R = 1.0, r = 0.25
      dir_table.push_back(mk(0, 0, 0, 0, 1, 65536, 16384, 0));
      dir_table.push_back(mk(1, 0, -1, 0, 1, 65536, -16384, 0));
      dir_table.push_back(mk(0, 0, 16384, 0, 1, 65536, 16384, 0));
      dir_table.push_back(mk(0, 16384, 0, 0, 1, 81920, 0, 0));
      dir_table.push_back(mk(0, 0, 0, -16384, 1, 0, 0, -81920));
      dir_table.push_back(mk(1, 16384, 16384, 0, 1, 81920, 16384, 0));
      dir_table.push_back(mk(0, -32768, -32768, -32768));
      dir_table.push_back(mk(1, 32767, 32767, 32767));
      dir_table.push_back(mk(0, -32768, 32767, 0));
      dir_table.push_back(mk(1, 0, -32768, 32767));
      dir_table.push_back(mk(0, 1, 1, 1));
      dir_table.push_back(mk(1, -1, -1, -1));
      dir_table.push_back(mk(0, 11585, 0, 11585));
      dir_table.push_back(mk(1, -9459, 9459, 9459));
      dir_table.push_back(mk(0, 0, -32768, 0));
      dir_table.push_back(mk(1, 0, 1, 1));
      dir_table.push_back(mk(0, 1, -32768, 0));
      dir_table.push_back(mk(1, -21846, 5461, 13107));
      foreach (dir_table[i]) send_dir(dir_table[i]);
      random_dirs(60);

      // margin larger than tube radius: negative tube
      set_radii(31'd131072, 31'd16384, 31'd49152);
      foreach (dir_table[i]) if (!dir_table[i].known) send_dir(dir_table[i]);
      random_dirs(90);
      // all zero
      set_radii(31'd0, 31'd0, 31'd0);
      random_dirs(70);
      // full scale: every radius at its maximum value
      set_radii(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
      foreach (dir_table[i]) if (!dir_table[i].known) send_dir(dir_table[i]);
      random_dirs(90);
      // small major, huge margin: deeply negative tube
      set_radii(31'd1, 31'd0, 31'h7FFFFFFF);
      random_dirs(80);
      // random settings
      for (int k = 0; k < 3; k++) begin
         set_radii(RadW'($urandom), RadW'($urandom_range(0, 31'h00FFFFFF)),
                   RadW'($urandom_range(0, 31'h00FFFFFF)));
         random_dirs(70);
      end
      req_valid <= 1'b0;

      while (pending_points.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d directions over 8 radius settings, %0d responses checked",
               sent, checked);
      $display("Settings covered reset values, negative tube, zero and full-scale radii");
      if (errors == 0 && pending_points.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* torus_support_point.f */
rtl/core/tsp_pkg.sv
rtl/core/tsp_delay.sv
rtl/core/tsp_isqrt.sv
rtl/core/tsp_div.sv
rtl/core/torus_support_point.sv
tb/sv/tb_top.sv
